// ===== rtl/pmrg_pkg.sv =====
// Shared types, constants and tables of the polar minimum range grid.
package pmrg_pkg;

  localparam int MaxCells    = 1024;
  localparam int CellW       = $clog2(MaxCells);
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int FullTurn    = 23040;
  localparam int HalfTurn    = 11520;
  localparam int QuarterFine = 23592960;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  localparam logic [1:0] CfgNumCells  = 2'd0;
  localparam logic [1:0] CfgMinAngle  = 2'd1;
  localparam logic [1:0] CfgAngleStep = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] x_mm;
    logic [15:0] y_mm;
    logic [9:0]  read_cell;
  } pmrg_in_t;

  typedef struct packed {
    logic [9:0]  cell_index;
    logic [15:0] range_mm;
    logic        cell_filled;
    logic        in_grid;
  } pmrg_out_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic cordic_step;
    logic sqrt_step;
    logic div_step;
    logic bearing;
    logic mem_read;
    logic mem_write;
    logic finish;
    logic clear_step;
  } pmrg_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic div_done;
    logic clear_done;
  } pmrg_sts_t;

  function automatic logic [25:0] atan_fine(input logic [StepW-1:0] i);
    logic [25:0] r;
    case (i)
      4'd0:  r = 26'd11796480;
      4'd1:  r = 26'd6963869;
      4'd2:  r = 26'd3679517;
      4'd3:  r = 26'd1867780;
      4'd4:  r = 26'd937515;
      4'd5:  r = 26'd469214;
      4'd6:  r = 26'd234664;
      4'd7:  r = 26'd117339;
      4'd8:  r = 26'd58671;
      4'd9:  r = 26'd29335;
      4'd10: r = 26'd14668;
      4'd11: r = 26'd7334;
      4'd12: r = 26'd3667;
      4'd13: r = 26'd1833;
      4'd14: r = 26'd917;
      default: r = 26'd458;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pmrg_if.sv =====
// Valid/ready channel interface carrying one payload.
interface pmrg_if #(parameter type payload_t = logic) (input logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pmrg_ctrl.sv =====
// Controller state machine sequencing the datapath for one command.
module pmrg_ctrl import pmrg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  pmrg_sts_t sts_i,
  output pmrg_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StInit, StIdle, StClear, StCalc, StBear, StDiv, StRead, StWrite, StFinish
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   insert_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load        = in_valid_i && in_ready_o;
    cmd_o.clear_step  = (state_q inside {StInit, StClear}) && !sts_i.clear_done;
    cmd_o.cordic_step = (state_q == StCalc) && !sts_i.cordic_done;
    cmd_o.sqrt_step   = (state_q == StCalc) && !sts_i.sqrt_done;
    cmd_o.bearing     = (state_q == StBear);
    cmd_o.div_step    = (state_q == StDiv) && !sts_i.div_done;
    cmd_o.mem_read    = (state_q == StRead);
    cmd_o.mem_write   = (state_q == StWrite);
    cmd_o.finish      = (state_q == StFinish) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      out_valid_q <= 1'b0;
      insert_q    <= 1'b0;
    end else begin
      if (state_q == StFinish && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StInit: if (sts_i.clear_done) state_q <= StIdle;
        StIdle: begin
          if (in_valid_i) begin
            insert_q <= (in_cmd_i == CmdInsert);
            case (in_cmd_i)
              CmdClear:  state_q <= StClear;
              CmdInsert: state_q <= StCalc;
              CmdRead:   state_q <= StRead;
              default:   state_q <= StFinish;
            endcase
          end
        end
        StClear: if (sts_i.clear_done) state_q <= StFinish;
        StCalc: if (sts_i.cordic_done && sts_i.sqrt_done) state_q <= StBear;
        StBear: state_q <= StDiv;
        StDiv: if (sts_i.div_done) state_q <= StRead;
        StRead: state_q <= StWrite;
        StWrite: state_q <= StFinish;
        StFinish: if (out_free) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q) else $error("result not presented");
  a_insert_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc) |-> insert_q) else $error("calc without insert");

endmodule

// ===== rtl/pmrg_dp.sv =====
// Datapath: CORDIC, square root, cell divider and grid memory.
module pmrg_dp import pmrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pmrg_in_t    in_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  pmrg_cmd_t   cmd_i,
  output pmrg_sts_t   sts_o,
  output pmrg_out_t   out_o
);

  logic [10:0] num_cells_q;
  logic [14:0] min_angle_q, angle_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cells_q  <= 11'd1024;
      min_angle_q  <= 15'd0;
      angle_step_q <= 15'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumCells:  num_cells_q  <= cfg_data_i[10:0];
        CfgMinAngle:  min_angle_q  <= cfg_data_i;
        CfgAngleStep: angle_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [1:0]  op_q;
  logic        xneg_q, yneg_q;
  logic [9:0]  rcell_q;
  logic [15:0] ax_q, ay_q;

  logic signed [27:0] cx_q, cy_q;
  logic signed [27:0] cz_q;
  logic [StepW:0] ci_q;
  logic [StepW-1:0] ci;
  logic signed [27:0] dx, dy;
  assign ci = ci_q[StepW-1:0];
  assign dx = cy_q >>> ci;
  assign dy = cx_q >>> ci;

  logic [31:0] sq_rem_q;
  logic [15:0] sq_root_q;
  logic [4:0]  sq_i_q;
  logic [33:0] sq_trial;
  logic [31:0] sq_rem_n;
  assign sq_rem_n = {sq_rem_q[29:0], 2'b00};

  logic [15:0] rng_q;

  logic [31:0] mag_q;
  logic [15:0] ax_n, ay_n;
  assign ax_n = in_i.x_mm[15] ? 16'(-in_i.x_mm) : in_i.x_mm;
  assign ay_n = in_i.y_mm[15] ? 16'(-in_i.y_mm) : in_i.y_mm;

  logic [26:0] zc;
  logic [14:0] q;
  logic [15:0] b0;
  logic [15:0] bear;
  always_comb begin
    if (cz_q < 0) zc = '0;
    else if (cz_q > 28'sd23592960) zc = 27'(QuarterFine);
    else zc = cz_q[26:0];
    if (ay_q == 0) q = 15'd0;
    else if (ax_q == 0) q = 15'd5760;
    else q = 15'((zc + 27'd2048) >> 12);
    if (!yneg_q) b0 = xneg_q ? 16'(HalfTurn) - 16'(q) : 16'(q);
    else b0 = xneg_q ? 16'(HalfTurn) + 16'(q) : 16'(FullTurn) - 16'(q);
    bear = (b0 >= 16'(FullTurn)) ? b0 - 16'(FullTurn) : b0;
  end

  logic        dneg_q;
  logic [31:0] num_q;
  logic [31:0] den_q;
  logic [16:0] quo_q;
  logic [31:0] rem_q;
  logic [4:0]  di_q;
  logic [31:0] rem_sh;
  logic [15:0] d_signed;
  logic [15:0] ad;
  assign d_signed = bear - {1'b0, min_angle_q};
  assign ad = d_signed[15] ? 16'(-d_signed) : d_signed;
  assign rem_sh = {rem_q[30:0], num_q[5'd16 - di_q]};

  logic [10:0] grid_size;
  assign grid_size = (num_cells_q > 11'(MaxCells)) ? 11'(MaxCells) : num_cells_q;

  // Each entry holds a filled flag above the stored range.
  logic [16:0] mem_q [MaxCells];
  logic [16:0] mem_rd_q;
  logic [CellW:0] clr_q;
  logic [CellW-1:0] cell_sel;
  logic cell_ok;
  assign cell_ok = (op_q == CmdRead)
                 ? ({1'b0, rcell_q} < grid_size)
                 : (angle_step_q != 0 && (!dneg_q || quo_q == 0) &&
                    quo_q < {6'd0, grid_size});
  assign cell_sel = (op_q == CmdRead) ? rcell_q : quo_q[CellW-1:0];

  logic [CellW-1:0] cell_q;
  logic ok_q;
  logic mem_upd;
  assign mem_upd = cmd_i.mem_write && op_q == CmdInsert && ok_q &&
                   (!mem_rd_q[16] || rng_q < mem_rd_q[15:0]);

  pmrg_out_t out_d;

  assign sts_o.cordic_done = ci_q[StepW];
  assign sts_o.sqrt_done   = (sq_i_q == 5'd16);
  assign sts_o.div_done    = (di_q == 5'd17);
  assign sts_o.clear_done  = clr_q[CellW];

  always_comb begin
    sq_trial = 34'({sq_rem_n} | 32'(mag_q[31:30])) - 34'({sq_root_q, 2'b01});
  end

  always_comb begin
    out_d = '0;
    case (op_q)
      CmdInsert: begin
        out_d.range_mm = rng_q;
        if (ok_q) begin
          out_d.cell_index  = 10'(cell_q);
          out_d.cell_filled = 1'b1;
          out_d.in_grid     = 1'b1;
        end
      end
      CmdRead: begin
        out_d.cell_index = rcell_q;
        if (ok_q) begin
          out_d.in_grid = 1'b1;
          if (mem_rd_q[16]) begin
            out_d.cell_filled = 1'b1;
            out_d.range_mm    = mem_rd_q[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  // The clearing pass empties one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + 1'b1;
    end else if (cmd_i.load) begin
      clr_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) mem_q[clr_q[CellW-1:0]] <= '0;
    else if (mem_upd) mem_q[cell_q] <= {1'b1, rng_q};
    if (cmd_i.mem_read) mem_rd_q <= mem_q[cell_sel];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_i.cmd;
      xneg_q  <= in_i.x_mm[15];
      yneg_q  <= in_i.y_mm[15];
      rcell_q <= in_i.read_cell;
      ax_q    <= ax_n;
      ay_q    <= ay_n;
      cx_q    <= 28'({ax_n, 8'd0});
      cy_q    <= 28'({ay_n, 8'd0});
      cz_q    <= '0;
      ci_q    <= '0;
      mag_q   <= 32'(ax_n) * 32'(ax_n) + 32'(ay_n) * 32'(ay_n);
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_i_q    <= '0;
      di_q      <= '0;
    end
    if (cmd_i.cordic_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + 28'(atan_fine(ci));
      end else begin
        cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - 28'(atan_fine(ci));
      end
      ci_q <= ci_q + 1'b1;
    end
    if (cmd_i.sqrt_step) begin
      mag_q  <= {mag_q[29:0], 2'b00};
      sq_i_q <= sq_i_q + 1'b1;
      if (!sq_trial[33]) begin
        sq_rem_q  <= sq_trial[31:0];
        sq_root_q <= {sq_root_q[14:0], 1'b1};
      end else begin
        sq_rem_q  <= sq_rem_n | 32'(mag_q[31:30]);
        sq_root_q <= {sq_root_q[14:0], 1'b0};
      end
    end
    if (sq_i_q == 5'd16 && cmd_i.bearing) begin
      rng_q <= (sq_rem_q > {16'd0, sq_root_q}) ? sq_root_q + 1'b1 : sq_root_q;
    end
    if (cmd_i.bearing) begin
      dneg_q <= d_signed[15];
      num_q  <= {15'd0, ad, 1'b0} + {17'd0, angle_step_q};
      den_q  <= {16'd0, angle_step_q, 1'b0};
      rem_q  <= '0;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      di_q <= di_q + 1'b1;
      if (rem_sh >= den_q) begin
        rem_q <= rem_sh - den_q;
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
    if (cmd_i.mem_read) begin
      cell_q <= cell_sel;
      ok_q   <= cell_ok;
    end
    if (cmd_i.finish) out_o <= out_d;
  end

  a_div_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.div_done && den_q != 0 |-> quo_q < 17'd49151) else $error("quotient too large");
  a_clear_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.clear_done |-> !cmd_i.clear_step) else $error("clear past the end");
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_step |-> !cmd_i.mem_write) else $error("two memory writes");
  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.sqrt_done |-> sq_root_q <= 16'd46341) else $error("root too large");

endmodule

// ===== rtl/polar_min_range_grid.sv =====
// Top level of the polar minimum range grid.
// Input channel in_if carries cmd, x_mm, y_mm and read_cell; output channel
// out_if carries cell_index, range_mm, cell_filled and in_grid. Each transfer
// on the input produces exactly one transfer on the output.
// A point insert runs 16 CORDIC iterations alongside a 16 step square root;
// a bearing step then loads a 17 step restoring divider that finds the cell,
// then a memory read and an update are done before the result is presented.
// A read does a memory read before its result is presented, and a clear
// empties one cell per cycle. One item is in flight at a time.
// After reset a clearing pass empties the grid before the first input is
// taken; configuration then holds 1024 cells, bearing zero at cell zero and
// one degree per cell.
// If the receiver stalls, the result is held in the output register; the
// block takes one further input, processes it and then holds its input until
// the waiting result has been transferred.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, which it does not enforce.
module polar_min_range_grid import pmrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  pmrg_if.sink        in_if,
  pmrg_if.source      out_if
);

  pmrg_cmd_t cmd;
  pmrg_sts_t sts;

  pmrg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_cmd_i   (in_if.data.cmd),
    .in_ready_o (in_if.ready),
    .out_ready_i(out_if.ready),
    .out_valid_o(out_if.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pmrg_dp u_dp (
    .clk_i, .rst_ni,
    .in_i      (in_if.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_o     (out_if.data)
  );

endmodule
